[rtl/core/oidl_pkg.sv]
// Package of shared types, constants and character helpers for the operator-ID checker.
`timescale 1ns / 1ps

package oidl_pkg;

  // Radix of the check-character alphabet.
  localparam int unsigned BASE = 36;
  // Position of the stored check character within the ID.
  localparam logic [4:0] POS_CHECK = 5'd15;
  // Position of the final character of a well-formed sequence.
  localparam logic [4:0] POS_FINAL = 5'd18;
  // Saturation value of the character counter.
  localparam logic [4:0] POS_MAX = 5'd31;
  // Default depth of the queue between the front and back parts.
  localparam int unsigned QUEUE_DEPTH_DEFAULT = 2;

  // Weight codes for a character.
  typedef enum logic [1:0] {
    WEIGHT_NONE = 2'd0,
    WEIGHT_ONE  = 2'd1,
    WEIGHT_TWO  = 2'd2
  } oidl_weight_t;

  // One classified character as handed from the front to the back.
  typedef struct packed {
    logic [5:0] contrib;    // quotient plus remainder by 36 of the weighted digit
    logic       is_check;   // character sits at the check-character position
    logic [7:0] char_code;  // raw character, kept for the check comparison
    logic       last;       // final character of the sequence
    logic       length_ok;  // sequence length was exactly nineteen
  } oidl_entry_t;

  // Map an ASCII character to a base-36 digit; anything else gives zero.
  function automatic logic [5:0] char_to_digit(input logic [7:0] c);
    logic [7:0] d;
    begin
      d = 8'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
        d = c - 8'h30;
      end else if (c >= 8'h61 && c <= 8'h7a) begin
        d = c - 8'h57;
      end else if (c >= 8'h41 && c <= 8'h5a) begin
        d = c - 8'h37;
      end
      return d[5:0];
    end
  endfunction

  // Map a value from 1 to 36 to its check character, with 36 printed as zero.
  function automatic logic [7:0] digit_to_char(input logic [5:0] v);
    logic [7:0] c;
    begin
      if (v <= 6'd9) begin
        c = 8'h30 + {2'b00, v};
      end else if (v < 6'(BASE)) begin
        c = 8'h57 + {2'b00, v};
      end else begin
        c = 8'h30;
      end
      return c;
    end
  endfunction

endpackage

[rtl/core/oidl_chan_if.sv]
// Valid/ready channel interfaces for the character input and the result output.
`timescale 1ns / 1ps

interface oidl_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       last;

  modport source (output valid, output char_code, output last, input ready);
  modport sink (input valid, input char_code, input last, output ready);
endinterface

interface oidl_out_if;
  logic       valid;
  logic       ready;
  logic       valid_res;
  logic       length_ok;
  logic [7:0] check_char;

  modport source (output valid, output valid_res, output length_ok, output check_char,
                  input ready);
  modport sink (input valid, input valid_res, input length_ok, input check_char,
                output ready);
endinterface

[rtl/core/oidl_front.sv]
// Front part: accepts character beats, tracks position and classifies each character.
`timescale 1ns / 1ps

module oidl_front (
  input  logic               clk,
  input  logic               rst_n,
  oidl_in_if.sink            in_chan,
  output logic               push_valid,
  output oidl_pkg::oidl_entry_t push_entry,
  input  logic               push_ready
);
  import oidl_pkg::*;

  logic [4:0]   pos_r;
  logic [4:0]   pos_nxt;
  logic         accept;
  oidl_weight_t weight;
  logic [5:0]   digit;
  logic [6:0]   dbl;
  logic [5:0]   contrib;

  assign in_chan.ready = push_ready;
  assign accept        = in_chan.valid && push_ready;

  // Weights alternate from the right of the nineteen-character string.
  always_comb begin
    weight = WEIGHT_NONE;
    if (pos_r >= 5'd3 && pos_r <= 5'd14) begin
      weight = pos_r[0] ? WEIGHT_TWO : WEIGHT_ONE;
    end else if (pos_r >= 5'd16 && pos_r <= POS_FINAL) begin
      weight = pos_r[0] ? WEIGHT_ONE : WEIGHT_TWO;
    end
  end

  // A doubled digit stays below 72, so one subtraction gives quotient plus remainder.
  assign digit = char_to_digit(in_chan.char_code);
  assign dbl   = {digit, 1'b0};

  always_comb begin
    unique case (weight)
      WEIGHT_TWO: contrib = (dbl >= 7'(BASE)) ? 6'(dbl - 7'd35) : dbl[5:0];
      WEIGHT_ONE: contrib = digit;
      default:    contrib = 6'd0;
    endcase
  end

  // Beat handed to the queue.
  always_comb begin
    push_valid           = in_chan.valid;
    push_entry.contrib   = contrib;
    push_entry.is_check  = (pos_r == POS_CHECK);
    push_entry.char_code = in_chan.char_code;
    push_entry.last      = in_chan.last;
    push_entry.length_ok = (pos_r == POS_FINAL);
  end

  // Position counter saturates and restarts after the final beat.
  always_comb begin
    pos_nxt = pos_r;
    if (accept) begin
      if (in_chan.last) begin
        pos_nxt = 5'd0;
      end else if (pos_r != POS_MAX) begin
        pos_nxt = pos_r + 5'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= 5'd0;
    end else begin
      pos_r <= pos_nxt;
    end
  end

  a_restart: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_chan.last |=> pos_r == 5'd0)
    else $error("position counter did not restart after the final beat");

  a_saturate: assert property (@(posedge clk) disable iff (!rst_n)
    accept && !in_chan.last && pos_r == POS_MAX |=> pos_r == POS_MAX)
    else $error("position counter wrapped instead of saturating");

  a_no_weight_at_check: assert property (@(posedge clk) disable iff (!rst_n)
    push_entry.is_check |-> push_entry.contrib == 6'd0)
    else $error("check-character position entered the digit sum");

endmodule

[rtl/core/oidl_queue.sv]
// Short first-in first-out queue of classified characters between front and back.
`timescale 1ns / 1ps

module oidl_queue #(
  parameter int unsigned DEPTH = oidl_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push_valid,
  input  oidl_pkg::oidl_entry_t push_entry,
  output logic                  push_ready,
  output logic                  pop_valid,
  output oidl_pkg::oidl_entry_t pop_entry,
  input  logic                  pop_ready
);
  import oidl_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  oidl_entry_t      entry_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [PTR_W-1:0] rd_ptr_nxt;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  logic             push;
  logic             pop;

  assign push_ready = (count_r != CNT_FULL);
  assign pop_valid  = (count_r != '0);
  assign pop_entry  = entry_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_ready && pop_valid;

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage needs no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_entry;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_FULL)
    else $error("queue fill count exceeds its depth");

  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    count_r == '0 || count_r == CNT_FULL |-> wr_ptr_r == rd_ptr_r)
    else $error("queue pointers disagree with an empty or full count");

  a_push_only: assert property (@(posedge clk) disable iff (!rst_n)
    push && !pop |=> count_r == $past(count_r) + CNT_W'(1))
    else $error("queue count missed a push");

endmodule

[rtl/core/oidl_back.sv]
// Back part: accumulates the digit sum and registers the result beat.
`timescale 1ns / 1ps

module oidl_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  pop_valid,
  input  oidl_pkg::oidl_entry_t pop_entry,
  output logic                  pop_ready,
  oidl_out_if.source            out_chan
);
  import oidl_pkg::*;

  logic [5:0] sum_r;
  logic [5:0] sum_nxt;
  logic [7:0] exp_r;
  logic [7:0] exp_nxt;
  logic       out_valid_r;
  logic       out_valid_nxt;
  logic       res_valid_r;
  logic       res_len_r;
  logic [7:0] res_chk_r;
  logic       out_free;
  logic       pop;
  logic       finish;
  logic [6:0] sum_add;
  logic [5:0] sum_new;
  logic [7:0] exp_new;
  logic [7:0] chk;

  // Only the final beat needs room in the output register.
  assign out_free  = !out_valid_r || out_chan.ready;
  assign pop_ready = !pop_entry.last || out_free;
  assign pop       = pop_valid && pop_ready;
  assign finish    = pop && pop_entry.last;

  // Sum kept modulo 36; both terms stay below 36, so one subtraction suffices.
  assign sum_add = {1'b0, sum_r} + {1'b0, pop_entry.contrib};
  assign sum_new = (sum_add >= 7'(BASE)) ? 6'(sum_add - 7'(BASE)) : sum_add[5:0];
  assign exp_new = pop_entry.is_check ? pop_entry.char_code : exp_r;
  assign chk     = digit_to_char(6'(BASE) - sum_new);

  // Accumulator state, cleared after the final beat.
  always_comb begin
    sum_nxt       = sum_r;
    exp_nxt       = exp_r;
    out_valid_nxt = out_valid_r;
    if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (finish) begin
      sum_nxt       = 6'd0;
      exp_nxt       = 8'd0;
      out_valid_nxt = 1'b1;
    end else if (pop) begin
      sum_nxt = sum_new;
      exp_nxt = exp_new;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r       <= 6'd0;
      exp_r       <= 8'd0;
      out_valid_r <= 1'b0;
    end else begin
      sum_r       <= sum_nxt;
      exp_r       <= exp_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload register.
  always_ff @(posedge clk) begin
    if (finish) begin
      res_len_r   <= pop_entry.length_ok;
      res_chk_r   <= chk;
      res_valid_r <= pop_entry.length_ok && (exp_new == chk);
    end
  end

  assign out_chan.valid      = out_valid_r;
  assign out_chan.valid_res  = res_valid_r;
  assign out_chan.length_ok  = res_len_r;
  assign out_chan.check_char = res_chk_r;

  a_sum_range: assert property (@(posedge clk) disable iff (!rst_n)
    sum_r < 6'(BASE))
    else $error("digit sum left its modulo range");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    finish |=> out_valid_r)
    else $error("final beat gave no result");

  a_clear_after_final: assert property (@(posedge clk) disable iff (!rst_n)
    finish |=> sum_r == 6'd0 && exp_r == 8'd0)
    else $error("accumulator not cleared after the final beat");

  a_valid_implies_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && res_valid_r |-> res_len_r)
    else $error("result marked valid without correct length");

endmodule

[rtl/core/operator_id_luhn36_checker.sv]
// Top level of the operator-ID base-36 Luhn check-character checker.
// Throughput: one character beat per cycle; the front takes a beat whenever the queue has room.
// A final character's beat is written into the queue when it is taken, and is moved into the
// output register once it leaves the queue and the output register is free or being read.
// Non-final characters give no result beat and never wait on the output register in the back part.
// Reset: synchronous, active low; clears the position counter, queue, sum and result valid.
`timescale 1ns / 1ps

module operator_id_luhn36_checker #(
  parameter int unsigned QUEUE_DEPTH = oidl_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic        clk,
  input  logic        rst_n,
  oidl_in_if.sink     in_chan,
  oidl_out_if.source  out_chan
);
  import oidl_pkg::*;

  logic        push_valid;
  logic        push_ready;
  oidl_entry_t push_entry;
  logic        pop_valid;
  logic        pop_ready;
  oidl_entry_t pop_entry;

  // Classify incoming characters.
  oidl_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_chan    (in_chan),
    .push_valid (push_valid),
    .push_entry (push_entry),
    .push_ready (push_ready)
  );

  // Decouple the two parts.
  oidl_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_entry (push_entry),
    .push_ready (push_ready),
    .pop_valid  (pop_valid),
    .pop_entry  (pop_entry),
    .pop_ready  (pop_ready)
  );

  // Accumulate and report.
  oidl_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_entry (pop_entry),
    .pop_ready (pop_ready),
    .out_chan  (out_chan)
  );

endmodule

[tb/sv/operator_id_luhn36_checker_test.sv]
// Self-checking testbench for the operator-ID base-36 Luhn check-character checker.
`timescale 1ns / 1ps

module operator_id_luhn36_checker_test;
  import oidl_pkg::*;

  // One result beat as the block reports it.
  typedef struct packed {
    logic       valid_res;
    logic       length_ok;
    logic [7:0] check_char;
  } verdict_t;

  // Running state of one character sequence.
  typedef struct packed {
    logic [4:0] pos;
    logic [9:0] sum;
    logic [7:0] stored;
  } seq_state_t;

  // One row of the directed table; the verdict is only used where typed is set.
  typedef struct packed {
    logic [7:0] code;
    logic       last;
    logic       typed;
    verdict_t   want;
  } dir_row_t;

  // Shapes of the random sequences.
  typedef enum int {
    SHAPE_VALID,
    SHAPE_CASE_FLIP,
    SHAPE_RANDOM_CHECK,
    SHAPE_ODD_LENGTH
  } seq_shape_t;

  localparam int unsigned RANDOM_BEATS = 1900;
  localparam int unsigned WELL_FORMED_LEN = 19;
  localparam verdict_t NO_VERDICT = '0;

  // Single characters after reset, a short pair, then a well-formed sequence of zeros.
  localparam dir_row_t DIRECTED_ROWS [23] = '{
    '{8'h00, 1'b1, 1'b1, '{1'b0, 1'b0, "0"}},
    '{8'hff, 1'b1, 1'b1, '{1'b0, 1'b0, "0"}},
    '{"A",   1'b0, 1'b0, NO_VERDICT},
    '{"z",   1'b1, 1'b1, '{1'b0, 1'b0, "0"}},
    '{"0",   1'b0, 1'b0, NO_VERDICT},
    '{"0",   1'b0, 1'b0, NO_VERDICT},
    '{"0",   1'b0, 1'b0, NO_VERDICT},
    '{"0",   1'b0, 1'b0, NO_VERDICT},
    '{"0",   1'b0, 1'b0, NO_VERDICT},
    '{"0",   1'b0, 1'b0, NO_VERDICT},
    '{"0",   1'b0, 1'b0, NO_VERDICT},
    '{"0",   1'b0, 1'b0, NO_VERDICT},
    '{"0",   1'b0, 1'b0, NO_VERDICT},
    '{"0",   1'b0, 1'b0, NO_VERDICT},
    '{"0",   1'b0, 1'b0, NO_VERDICT},
    '{"0",   1'b0, 1'b0, NO_VERDICT},
    '{"0",   1'b0, 1'b0, NO_VERDICT},
    '{"0",   1'b0, 1'b0, NO_VERDICT},
    '{"0",   1'b0, 1'b0, NO_VERDICT},
    '{"0",   1'b0, 1'b0, NO_VERDICT},
    '{"0",   1'b0, 1'b0, NO_VERDICT},
    '{"0",   1'b0, 1'b0, NO_VERDICT},
    '{"0",   1'b1, 1'b1, '{1'b1, 1'b1, "0"}}
  };

  logic clk = 1'b0;
  logic rst_n;
  logic sink_ready = 1'b0;

  oidl_in_if  in_chan ();
  oidl_out_if out_chan ();

  assign out_chan.ready = sink_ready;

  operator_id_luhn36_checker i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  always #5 clk = ~clk;

  seq_state_t  seq_state = '0;
  verdict_t    pending_verdicts [$];
  int unsigned beats_sent = 0;
  int unsigned mismatch_count = 0;
  int unsigned cycle_no = 0;

  // Base-36 value of a character; anything that is not alphanumeric counts as zero.
  function automatic logic [5:0] base36_digit(input logic [7:0] c);
    logic [7:0] d;
    d = 8'd0;
    if (c >= "0" && c <= "9") begin
      d = c - "0";
    end else if (c >= "a" && c <= "z") begin
      d = c - "a" + 8'd10;
    end else if (c >= "A" && c <= "Z") begin
      d = c - "A" + 8'd10;
    end
    return d[5:0];
  endfunction

  // Advance a sequence by one character and give the verdict on a final character.
  function automatic void luhn_step(inout seq_state_t st, input logic [7:0] c,
                                    input logic is_last, output bit emits,
                                    output verdict_t v);
    oidl_weight_t w;
    logic [6:0]   prod;
    logic [6:0]   val;
    w = WEIGHT_NONE;
    if (st.pos >= 5'd3 && st.pos <= 5'd14) begin
      w = st.pos[0] ? WEIGHT_TWO : WEIGHT_ONE;
    end else if (st.pos > POS_CHECK && st.pos <= POS_FINAL) begin
      w = st.pos[0] ? WEIGHT_ONE : WEIGHT_TWO;
    end
    prod = 7'(base36_digit(c) * ((w == WEIGHT_TWO) ? 2 : (w == WEIGHT_ONE) ? 1 : 0));
    st.sum = 10'(st.sum + prod / BASE + prod % BASE);
    if (st.pos == POS_CHECK) begin
      st.stored = c;
    end
    if (st.pos != POS_MAX) begin
      st.pos = st.pos + 5'd1;
    end
    emits = is_last;
    v = '0;
    if (is_last) begin
      val = 7'(BASE - (st.sum % BASE));
      if (val <= 7'd9) begin
        v.check_char = "0" + val;
      end else if (val < BASE) begin
        v.check_char = "a" + val - 7'd10;
      end else begin
        v.check_char = "0";
      end
      v.length_ok = (st.pos == POS_FINAL + 5'd1);
      v.valid_res = v.length_ok && (st.stored == v.check_char);
      st = '0;
    end
  endfunction

  // Check character that a whole sequence would earn.
  function automatic logic [7:0] check_of(input logic [7:0] chars [$]);
    seq_state_t st;
    bit         emits;
    verdict_t   v;
    st = '0;
    v = '0;
    foreach (chars[i]) begin
      luhn_step(st, chars[i], i == chars.size() - 1, emits, v);
    end
    return v.check_char;
  endfunction

  // A character drawn evenly from digits, both letter cases and the full byte range.
  function automatic logic [7:0] rand_char();
    case ($urandom_range(0, 3))
      0: return 8'($urandom_range("0", "9"));
      1: return 8'($urandom_range("a", "z"));
      2: return 8'($urandom_range("A", "Z"));
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Offer one character beat, with random idle cycles except in the quiet stretch.
  task automatic send_beat(input logic [7:0] c, input logic is_last, input logic typed,
                           input verdict_t want);
    bit       emits;
    verdict_t v;
    if (!(beats_sent >= 1200 && beats_sent < 1500)) begin
      while ($urandom_range(0, 99) < 18) begin
        in_chan.valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_chan.valid     <= 1'b1;
    in_chan.char_code <= c;
    in_chan.last      <= is_last;
    do @(posedge clk); while (!in_chan.ready);
    beats_sent++;
    luhn_step(seq_state, c, is_last, emits, v);
    if (emits) begin
      pending_verdicts.push_back(typed ? want : v);
    end
  endtask

  // Stimulus: reset, the directed table, then random sequences.
  initial begin
    logic [7:0] seq [$];
    seq_shape_t shape;
    int         pick;
    int         len;
    int         k;
    logic [7:0] chk;
    rst_n             <= 1'b0;
    in_chan.valid     <= 1'b0;
    in_chan.char_code <= 8'h00;
    in_chan.last      <= 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (DIRECTED_ROWS[i]) begin
      send_beat(DIRECTED_ROWS[i].code, DIRECTED_ROWS[i].last, DIRECTED_ROWS[i].typed,
                DIRECTED_ROWS[i].want);
    end

    // Mostly well-formed sequences with random content; the rest of odd length.
    while (beats_sent < RANDOM_BEATS) begin
      pick = $urandom_range(0, 99);
      shape = (pick < 35) ? SHAPE_VALID :
              (pick < 45) ? SHAPE_CASE_FLIP :
              (pick < 75) ? SHAPE_RANDOM_CHECK : SHAPE_ODD_LENGTH;
      len = (shape == SHAPE_ODD_LENGTH) ? $urandom_range(1, 40) : WELL_FORMED_LEN;
      seq.delete();
      for (k = 0; k < len; k++) begin
        seq.push_back(rand_char());
      end
      if (shape != SHAPE_ODD_LENGTH && shape != SHAPE_RANDOM_CHECK) begin
        // The check position does not enter the sum, so it can be set afterwards.
        chk = check_of(seq);
        if (shape == SHAPE_CASE_FLIP && chk >= "a") begin
          chk = chk - 8'h20;
        end
        seq[POS_CHECK] = chk;
      end
      foreach (seq[i]) begin
        send_beat(seq[i], i == seq.size() - 1, 1'b0, NO_VERDICT);
      end
    end
    in_chan.valid <= 1'b0;

    // Drain what is still due, then let the pipeline settle before the final check.
    for (k = 0; k < 1000 && pending_verdicts.size() != 0; k++) begin
      @(posedge clk);
    end
    repeat (8) @(posedge clk);
    if (pending_verdicts.size() != 0) begin
      $display("%0t: %0d expected result beats never arrived", $time,
               pending_verdicts.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Result side: random stalls, one long hold-off that fills the block, a quiet stretch.
  always @(posedge clk) begin : result_check
    verdict_t want;
    verdict_t got;
    cycle_no++;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      got = '{out_chan.valid_res, out_chan.length_ok, out_chan.check_char};
      if (pending_verdicts.size() == 0) begin
        $display("%0t: unexpected result beat, actual %p", $time, got);
        mismatch_count++;
      end else begin
        want = pending_verdicts.pop_front();
        if (got.valid_res !== want.valid_res) begin
          $display("%0t: valid_res expected %0b actual %0b", $time, want.valid_res,
                   got.valid_res);
          mismatch_count++;
        end
        if (got.length_ok !== want.length_ok) begin
          $display("%0t: length_ok expected %0b actual %0b", $time, want.length_ok,
                   got.length_ok);
          mismatch_count++;
        end
        if (got.check_char !== want.check_char) begin
          $display("%0t: check_char expected %h actual %h", $time, want.check_char,
                   got.check_char);
          mismatch_count++;
        end
      end
    end
    if (cycle_no >= 600 && cycle_no < 800) begin
      sink_ready <= 1'b0;
    end else if (cycle_no >= 1500 && cycle_no < 2000) begin
      sink_ready <= 1'b1;
    end else begin
      sink_ready <= ($urandom_range(0, 99) >= 18);
    end
  end

  // Watchdog against a hung handshake.
  initial begin
    #2_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
